>>> src/lie_pkg.sv
package lie_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned PROD_W = 64;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [1:0] FAULT_OK  = 2'd0;
  localparam logic [1:0] FAULT_OVF = 2'd1;
  localparam logic [1:0] FAULT_DUP = 2'd2;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DIFF_W-1:0] divisor;
  } lie_div_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] quot;
  } lie_div_rsp_t;

endpackage

>>> src/lagrange_interpolation_eval_core.sv
// Eight-node Lagrange interpolator in signed Q16.16. A load (in_func = 0) writes one node in
// the cycle it is taken and gives no result; busy stays low. An evaluate (in_func = 1) holds
// busy high while one sequencer walks the node table: a duplicate check over all node pairs
// (one compare per cycle), then for each basis term NODE_COUNT-1 steps, each one multiply and
// a restoring divide of 32 quotient bits in the shared divider. The result appears for one
// cycle with out_valid and must be captured then; there is no way to stall it.
module lagrange_interpolation_eval_core #(
  parameter int unsigned NODE_COUNT = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [2:0]  in_node_index,
  input  logic signed [31:0] in_node_x_value,
  input  logic signed [31:0] in_node_y_value,
  input  logic signed [31:0] in_eval_x,
  output logic        out_valid,
  output logic signed [31:0] out_interp_value,
  output logic [1:0]  out_fault
);

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);
  localparam int unsigned DW = lie_pkg::DATA_W;
  localparam int unsigned XW = lie_pkg::DIFF_W;
  localparam int unsigned PW = lie_pkg::PROD_W;
  localparam logic [CW-1:0] LAST = CW'(NODE_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DUP_LD, S_DUP_CMP, S_TERM_LD, S_STEP, S_DIV, S_TERM_MUL, S_TERM_ACC, S_FINISH
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       i_r, j_r;
  logic [DW-1:0]       x_r, xi_r, yi_r;
  logic                m_neg_r;
  logic [DW-1:0]       m_mag_r;
  logic [PW-1:0]       prod_r;
  logic [XW-1:0]       den_r;
  logic                sign_r;
  logic signed [PW-1:0] sum_r;
  logic                ovf_r;
  logic                div_start_r;
  logic                out_valid_r;
  logic [DW-1:0]       out_value_r;
  logic [1:0]          out_fault_r;

  logic                wr_en;
  logic [IW-1:0]       rd_addr;
  logic [DW-1:0]       rd_x, rd_y;
  logic signed [XW-1:0] num, den;
  logic [XW-1:0]       num_mag, den_mag, mul_b;
  logic [XW+DW-1:0]    mul_p;
  logic [PW-1:0]       term;
  logic signed [PW-1:0] sum_nxt;
  lie_pkg::lie_div_req_t div_req;
  lie_pkg::lie_div_rsp_t div_rsp;

  assign busy = (state_r != S_IDLE);
  assign wr_en = start && !busy && (in_func == lie_pkg::FUNC_LOAD)
                 && (32'(in_node_index) < NODE_COUNT);
  assign rd_addr = ((state_r == S_DUP_CMP) || (state_r == S_STEP)) ? j_r[IW-1:0] : i_r[IW-1:0];

  lie_nodes #(.NODE_COUNT(NODE_COUNT)) u_nodes (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (IW'(in_node_index)),
    .wr_x    (in_node_x_value),
    .wr_y    (in_node_y_value),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  assign div_req.start    = div_start_r;
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = den_r;

  lie_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign num     = $signed({x_r[DW-1], x_r}) - $signed({rd_x[DW-1], rd_x});
  assign den     = $signed({xi_r[DW-1], xi_r}) - $signed({rd_x[DW-1], rd_x});
  assign num_mag = num[XW-1] ? XW'(-num) : XW'(num);
  assign den_mag = den[XW-1] ? XW'(-den) : XW'(den);
  assign mul_b   = (state_r == S_TERM_MUL)
                   ? (yi_r[DW-1] ? {1'b0, DW'(-yi_r)} : {1'b0, yi_r}) : num_mag;
  assign mul_p   = m_mag_r * mul_b;
  assign term    = prod_r >> FRAC_BITS;
  assign sum_nxt = sign_r ? sum_r - $signed(term) : sum_r + $signed(term);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && in_func == lie_pkg::FUNC_EVAL) begin
            x_r     <= in_eval_x;
            i_r     <= '0;
            sum_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_DUP_LD;
          end
        end
        S_DUP_LD: begin
          xi_r    <= rd_x;
          j_r     <= i_r + CW'(1);
          state_r <= S_DUP_CMP;
        end
        S_DUP_CMP: begin
          if (rd_x == xi_r) begin
            out_valid_r <= 1'b1;
            out_value_r <= '0;
            out_fault_r <= lie_pkg::FAULT_DUP;
            state_r     <= S_IDLE;
          end else if (j_r == LAST) begin
            if (i_r == LAST - CW'(1)) begin
              i_r     <= '0;
              state_r <= S_TERM_LD;
            end else begin
              i_r     <= i_r + CW'(1);
              state_r <= S_DUP_LD;
            end
          end else begin
            j_r <= j_r + CW'(1);
          end
        end
        S_TERM_LD: begin
          xi_r    <= rd_x;
          yi_r    <= rd_y;
          m_neg_r <= 1'b0;
          m_mag_r <= DW'(1) << FRAC_BITS;
          j_r     <= '0;
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (j_r == i_r) begin
            if (j_r == LAST) begin
              state_r <= S_TERM_MUL;
            end else begin
              j_r <= j_r + CW'(1);
            end
          end else begin
            prod_r      <= mul_p[PW-1:0];
            den_r       <= den_mag;
            sign_r      <= m_neg_r ^ num[XW-1] ^ den[XW-1];
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (sign_r) begin
              if (div_rsp.sat || (div_rsp.quot[DW-1] && div_rsp.quot[DW-2:0] != '0)) begin
                m_neg_r <= 1'b1;
                m_mag_r <= DW'(1) << (DW - 1);
                ovf_r   <= 1'b1;
              end else begin
                m_neg_r <= (div_rsp.quot != '0);
                m_mag_r <= div_rsp.quot;
              end
            end else if (div_rsp.sat || div_rsp.quot[DW-1]) begin
              m_neg_r <= 1'b0;
              m_mag_r <= {1'b0, {(DW-1){1'b1}}};
              ovf_r   <= 1'b1;
            end else begin
              m_neg_r <= 1'b0;
              m_mag_r <= div_rsp.quot;
            end
            if (j_r == LAST) begin
              state_r <= S_TERM_MUL;
            end else begin
              j_r     <= j_r + CW'(1);
              state_r <= S_STEP;
            end
          end
        end
        S_TERM_MUL: begin
          prod_r  <= mul_p[PW-1:0];
          sign_r  <= yi_r[DW-1] ^ m_neg_r;
          state_r <= S_TERM_ACC;
        end
        S_TERM_ACC: begin
          sum_r <= sum_nxt;
          if (i_r == LAST) begin
            state_r <= S_FINISH;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_TERM_LD;
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          if (sum_r > $signed(PW'(32'sh7FFF_FFFF))) begin
            out_value_r <= 32'h7FFF_FFFF;
            out_fault_r <= lie_pkg::FAULT_OVF;
          end else if (sum_r < -$signed(PW'(33'h0_8000_0000))) begin
            out_value_r <= 32'h8000_0000;
            out_fault_r <= lie_pkg::FAULT_OVF;
          end else begin
            out_value_r <= sum_r[DW-1:0];
            out_fault_r <= ovf_r ? lie_pkg::FAULT_OVF : lie_pkg::FAULT_OK;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_fault        = out_fault_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without evaluation");
  a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault == lie_pkg::FAULT_DUP) |-> out_interp_value == 32'sd0)
    else $error("duplicate fault with nonzero value");
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == lie_pkg::FUNC_EVAL) |=> busy)
    else $error("evaluate transfer not started");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV) else $error("divider done outside divide step");

endmodule

>>> src/lie_nodes.sv
module lie_nodes #(
  parameter int unsigned NODE_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  input  logic [lie_pkg::DATA_W-1:0]    wr_x,
  input  logic [lie_pkg::DATA_W-1:0]    wr_y,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  output logic [lie_pkg::DATA_W-1:0]    rd_x,
  output logic [lie_pkg::DATA_W-1:0]    rd_y
);

  logic [lie_pkg::DATA_W-1:0] abscissa_r [NODE_COUNT];
  logic [lie_pkg::DATA_W-1:0] ordinate_r [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NODE_COUNT; k++) begin
        abscissa_r[k] <= '0;
        ordinate_r[k] <= '0;
      end
    end else if (wr_en) begin
      abscissa_r[wr_addr] <= wr_x;
      ordinate_r[wr_addr] <= wr_y;
    end
  end

  assign rd_x = abscissa_r[rd_addr];
  assign rd_y = ordinate_r[rd_addr];

endmodule

>>> src/lie_div.sv
module lie_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lie_pkg::lie_div_req_t req,
  output lie_pkg::lie_div_rsp_t rsp
);

  logic [lie_pkg::DIFF_W-1:0] rem_r;
  logic [lie_pkg::DIFF_W-1:0] dsr_r;
  logic [lie_pkg::DATA_W-1:0] quo_r;
  logic [5:0]                 cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic                       sat_r;
  logic [lie_pkg::DIFF_W:0]   trial;
  logic                       fits;

  assign trial = {rem_r, quo_r[lie_pkg::DATA_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dsr_r <= req.divisor;
        if ({1'b0, req.dividend[63:32]} >= req.divisor) begin
          sat_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          sat_r <= 1'b0;
          rem_r <= {1'b0, req.dividend[63:32]};
          quo_r <= req.dividend[31:0];
          cnt_r <= 6'd32;
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        rem_r <= fits ? lie_pkg::DIFF_W'(trial - {1'b0, dsr_r}) : trial[lie_pkg::DIFF_W-1:0];
        quo_r <= {quo_r[lie_pkg::DATA_W-2:0], fits};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.quot = quo_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int NODES      = 8;
  localparam int FRAC       = 16;
  localparam int MAX_WAIT   = 11;
  localparam int DRAIN      = 3000;
  localparam longint LIMIT  = 10_000_000;
  localparam longint POS_LIM = 64'sd2147483647;
  localparam longint NEG_LIM = -64'sd2147483648;

  typedef struct {
    logic        func;
    logic [2:0]  idx;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] ex;
  } node_cmd_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  fault;
  } interp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = lie_pkg::FUNC_LOAD;
  logic [2:0]  in_node_index = '0;
  logic signed [31:0] in_node_x_value = '0;
  logic signed [31:0] in_node_y_value = '0;
  logic signed [31:0] in_eval_x = '0;
  logic        out_valid;
  logic signed [31:0] out_interp_value;
  logic [1:0]  out_fault;

  node_cmd_t pending_cmds[$];
  interp_t   expected_interp[$];
  longint    abscissa[NODES];
  longint    ordinate[NODES];
  node_cmd_t active_cmd;
  int        gap_left = 0;
  int        errors = 0;
  longint    cycles = 0;
  bit        stim_done = 1'b0;

  lagrange_interpolation_eval_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_node_index(in_node_index),
    .in_node_x_value(in_node_x_value), .in_node_y_value(in_node_y_value),
    .in_eval_x(in_eval_x), .out_valid(out_valid),
    .out_interp_value(out_interp_value), .out_fault(out_fault)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic interp_t eval_lagrange(logic [31:0] ex);
    interp_t r;
    longint x, m, num, den, total;
    logic [63:0] q, tm;
    bit neg, ovf;
    r.value = '0;
    r.fault = lie_pkg::FAULT_OK;
    for (int i = 0; i < NODES; i++)
      for (int j = i + 1; j < NODES; j++)
        if (abscissa[i] == abscissa[j]) begin
          r.fault = lie_pkg::FAULT_DUP;
          return r;
        end
    x = longint'($signed(ex));
    total = 0;
    ovf = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      m = longint'(1) << FRAC;
      for (int j = 0; j < NODES; j++) begin
        if (j == i) continue;
        num = x - abscissa[j];
        den = abscissa[i] - abscissa[j];
        neg = ((m < 0) != (num < 0)) != (den < 0);
        q = (magnitude(m) * magnitude(num)) / magnitude(den);
        if (q == 0) neg = 1'b0;
        if (neg) begin
          if (q > 64'd2147483648) begin
            ovf = 1'b1;
            m = NEG_LIM;
          end else m = -longint'(q);
        end else begin
          if (q > 64'd2147483647) begin
            ovf = 1'b1;
            m = POS_LIM;
          end else m = longint'(q);
        end
      end
      tm = (magnitude(ordinate[i]) * magnitude(m)) >> FRAC;
      if ((ordinate[i] < 0) != (m < 0)) total -= longint'(tm);
      else total += longint'(tm);
    end
    if (total > POS_LIM) begin
      total = POS_LIM;
      ovf = 1'b1;
    end else if (total < NEG_LIM) begin
      total = NEG_LIM;
      ovf = 1'b1;
    end
    r.value = total[31:0];
    r.fault = ovf ? lie_pkg::FAULT_OVF : lie_pkg::FAULT_OK;
    return r;
  endfunction

  function automatic void apply_cmd(node_cmd_t c);
    if (c.func == lie_pkg::FUNC_LOAD) begin
      abscissa[c.idx] = longint'($signed(c.nx));
      ordinate[c.idx] = longint'($signed(c.ny));
    end else expected_interp.push_back(eval_lagrange(c.ex));
  endfunction

  function automatic void add_load(int idx, logic [31:0] nx, logic [31:0] ny);
    node_cmd_t c;
    c.func = lie_pkg::FUNC_LOAD;
    c.idx = idx[2:0];
    c.nx = nx;
    c.ny = ny;
    c.ex = $urandom;
    pending_cmds.push_back(c);
  endfunction

  function automatic void add_eval(logic [31:0] ex);
    node_cmd_t c;
    c.func = lie_pkg::FUNC_EVAL;
    c.idx = 3'($urandom);
    c.nx = $urandom;
    c.ny = $urandom;
    c.ex = ex;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [31:0] small_val();
    return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  function automatic void add_node_set();
    int order[NODES];
    int base, step, k, t;
    base = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                       : $urandom_range(32'h100, 32'h4_0000);
    if ($urandom_range(0, 1)) step = -step;
    for (int i = 0; i < NODES; i++) order[i] = i;
    for (int i = NODES - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    for (int i = 0; i < NODES; i++)
      add_load(order[i], 32'(base + i * step), small_val());
    for (int e = $urandom_range(1, 4); e > 0; e--)
      case ($urandom_range(0, 5))
        0: add_eval($urandom);
        1: add_eval(32'(base + $urandom_range(0, NODES - 1) * step));
        default: add_eval(32'(base + $signed($urandom_range(0, 9 * step)) - step / 2));
      endcase
  endfunction

  initial begin
    add_eval(32'h0001_0000);
    for (int i = 0; i < NODES; i++)
      add_load(i, 32'((i - 4) <<< 16), 32'((i * i) <<< 16));
    add_eval(32'h0000_0000);
    add_eval(32'h0003_8000);
    add_eval(32'h7FFF_FFFF);
    add_eval(32'h8000_0000);
    add_eval(32'hFFFF_FFFF);
    add_load(7, 32'h7FFF_FFFF, 32'h8000_0000);
    add_load(0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_eval(32'h0000_0000);
    add_eval(32'h7FFF_FFFF);
    add_load(3, 32'h8000_0000, 32'hFFFF_FFFF);
    add_eval(32'h1234_5678);
    while (pending_cmds.size() < 1500) begin
      case ($urandom_range(0, 9))
        0: add_load($urandom_range(0, 7), $urandom, $urandom);
        1: add_eval($urandom);
        default: add_node_set();
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      apply_cmd(active_cmd);
      gap_left = $urandom_range(0, MAX_WAIT);
      if (gap_left == 0 && pending_cmds.size() > 0) begin
        active_cmd = pending_cmds.pop_front();
        in_func <= active_cmd.func;
        in_node_index <= active_cmd.idx;
        in_node_x_value <= active_cmd.nx;
        in_node_y_value <= active_cmd.ny;
        in_eval_x <= active_cmd.ex;
      end else begin
        start <= 1'b0;
        if (pending_cmds.size() == 0) stim_done = 1'b1;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        active_cmd = pending_cmds.pop_front();
        in_func <= active_cmd.func;
        in_node_index <= active_cmd.idx;
        in_node_x_value <= active_cmd.nx;
        in_node_y_value <= active_cmd.ny;
        in_eval_x <= active_cmd.ex;
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    interp_t want;
    if (rst_n && out_valid) begin
      if (expected_interp.size() == 0) begin
        $display("%0t: unexpected result value=%h fault=%0d", $time,
                 out_interp_value, out_fault);
        errors++;
      end else begin
        want = expected_interp.pop_front();
        if (out_interp_value !== want.value) begin
          $display("%0t: interp_value expected %h actual %h", $time, want.value,
                   out_interp_value);
          errors++;
        end
        if (out_fault !== want.fault) begin
          $display("%0t: fault expected %0d actual %0d", $time, want.fault, out_fault);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_interp.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_interp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lie_pkg.sv
src/lie_nodes.sv
src/lie_div.sv
src/lagrange_interpolation_eval_core.sv
tb/testbench.sv
